// File: hw/rtl/lpct_pkg.sv
package lpct_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } lpct_op_e;

  localparam logic [9:0] ADDR_CSR = 10'd0;
  localparam logic [9:0] ADDR_PSR = 10'd1;
  localparam logic [9:0] ADDR_CMR = 10'd2;
  localparam logic [9:0] ADDR_CNR = 10'd3;

  localparam int unsigned CSR_TEN_BIT  = 0;
  localparam int unsigned CSR_TIE_BIT  = 6;
  localparam int unsigned CSR_TCF_BIT  = 7;
  localparam int unsigned PSR_PBYP_BIT = 2;
  localparam int unsigned PSR_PRE_LSB  = 3;
  localparam int unsigned PSR_PRE_MSB  = 6;

  localparam int unsigned PRESC_BITS = 15;
  localparam int unsigned SHIFT_BITS = 4;

  typedef logic [9:0]  lpct_addr_t;
  typedef logic [31:0] lpct_word_t;

endpackage

// File: hw/rtl/lpct_if.sv
interface lpct_in_if
  import lpct_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  lpct_addr_t addr;
  lpct_word_t wdata;

  modport source (output valid, output op, output addr, output wdata, input ready);
  modport sink (input valid, input op, input addr, input wdata, output ready);
endinterface

interface lpct_out_if
  import lpct_pkg::*;
();
  logic       valid;
  logic       ready;
  lpct_word_t rdata;
  logic       irq;

  modport source (output valid, output rdata, output irq, input ready);
  modport sink (input valid, input rdata, input irq, output ready);
endinterface

// File: hw/rtl/low_power_compare_timer.sv
// Register-mapped low-power compare timer.
// The input channel carries one beat per bus read, bus write or source-clock
// tick (op, addr, wdata). The output channel returns exactly one beat for
// every input beat, in order, with rdata (read data, zero for writes and
// ticks) and irq, the interrupt line as it stands after that beat.
// A beat updates the timer state at the clock edge where it is accepted, and
// its result is written into the output register at that same edge.
// Throughput is one beat per cycle while the receiver keeps up; the timer state
// update and the result both come from one pass of logic at the input.
// The output register lets a new beat in whenever it is empty or is being
// taken in the same cycle, so a stalled receiver holds at most one result
// and the input stalls only while that result waits.
// Reset clears all registers, including the counters and the prescaler
// shift, and empties the output register.
module low_power_compare_timer
  import lpct_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpct_in_if.sink     in_i,
  lpct_out_if.source  out_o
);

  lpct_word_t             csr_q, csr_d;
  lpct_word_t             psr_q, psr_d;
  lpct_word_t             cmr_q, cmr_d;
  logic [COUNT_BITS-1:0]  tick_q, tick_d;
  logic [PRESC_BITS-1:0]  presc_q, presc_d;
  logic [SHIFT_BITS-1:0]  shift_q, shift_d;

  logic                   out_valid_q;
  lpct_word_t             rdata_q, rdata_d;
  logic                   irq_q, irq_d;

  logic                   in_fire;
  logic                   restart;
  logic [PRESC_BITS-1:0]  presc_top;
  logic [COUNT_BITS-1:0]  cmp_val;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign presc_top = PRESC_BITS'((16'd1 << shift_q) - 16'd1);
  assign cmp_val   = cmr_q[COUNT_BITS-1:0];

  always_comb begin
    csr_d   = csr_q;
    psr_d   = psr_q;
    cmr_d   = cmr_q;
    tick_d  = tick_q;
    presc_d = presc_q;
    shift_d = shift_q;
    rdata_d = '0;
    restart = 1'b0;

    case (lpct_op_e'(in_i.op))
      OP_READ: begin
        unique case (in_i.addr)
          ADDR_CSR: rdata_d = csr_q;
          ADDR_PSR: rdata_d = psr_q;
          ADDR_CMR: rdata_d = cmr_q;
          ADDR_CNR: rdata_d = 32'(tick_q);
          default:  rdata_d = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (in_i.addr)
          ADDR_CSR: begin
            csr_d              = in_i.wdata;
            csr_d[CSR_TCF_BIT] = csr_q[CSR_TCF_BIT] && !in_i.wdata[CSR_TCF_BIT];
            restart            = !csr_q[CSR_TEN_BIT] && in_i.wdata[CSR_TEN_BIT];
          end
          ADDR_PSR: psr_d = in_i.wdata;
          ADDR_CMR: begin
            cmr_d   = in_i.wdata;
            restart = csr_q[CSR_TEN_BIT];
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (csr_q[CSR_TEN_BIT]) begin
          if (presc_q < presc_top) begin
            presc_d = presc_q + PRESC_BITS'(1);
          end else begin
            presc_d = '0;
            if (tick_q == cmp_val) begin
              tick_d             = '0;
              csr_d[CSR_TCF_BIT] = 1'b1;
            end else begin
              tick_d = tick_q + COUNT_BITS'(1);
            end
          end
        end
      end
      default: ;
    endcase

    if (restart) begin
      tick_d  = '0;
      presc_d = '0;
      shift_d = psr_q[PSR_PBYP_BIT] ? '0 : psr_q[PSR_PRE_MSB:PSR_PRE_LSB];
    end

    irq_d = csr_d[CSR_TCF_BIT] && csr_d[CSR_TIE_BIT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csr_q   <= '0;
      psr_q   <= '0;
      cmr_q   <= '0;
      tick_q  <= '0;
      presc_q <= '0;
      shift_q <= '0;
    end else if (in_fire) begin
      csr_q   <= csr_d;
      psr_q   <= psr_d;
      cmr_q   <= cmr_d;
      tick_q  <= tick_d;
      presc_q <= presc_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdata_q <= '0;
      irq_q   <= 1'b0;
    end else if (in_fire) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.rdata = rdata_q;
  assign out_o.irq   = irq_q;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("Accepted beat produced no result.");

  a_irq_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (irq_q == (csr_q[CSR_TCF_BIT] && csr_q[CSR_TIE_BIT])))
    else $error("Pending irq does not match the control state.");

  a_presc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    presc_q <= presc_top)
    else $error("Prescale counter beyond its top value.");

  a_disabled_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.op == OP_TICK) && !csr_q[CSR_TEN_BIT]) |=> $stable(tick_q))
    else $error("Tick counter moved while the timer was disabled.");

endmodule
